### hw/rtl/stbs_pkg.sv
// Shared definitions for the sorted table binary search block.
// Holds the command codes and the controller to datapath command and status structs.
// No dependencies.
`default_nettype none

package stbs_pkg;

   // Kind of an input beat, carried on req_tuser.
   localparam logic CMD_WRITE  = 1'b0;
   localparam logic CMD_SEARCH = 1'b1;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic wr;      // Store the accepted beat's value in the table.
      logic start;   // Latch the key and set the bounds to the first table_length entries.
      logic probe;   // Take the next bounds and read the table at their midpoint.
      logic narrow;  // Next bounds come from the last compare, not the current bounds.
      logic finish;  // Load the result register.
      logic hit;     // Result is a match at the current midpoint.
   } dp_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic hit;         // Key equals the entry read at the current midpoint.
      logic next_empty;  // The next bounds enclose no entry.
      logic rsp_free;    // The result register can take a result this cycle.
   } dp_status_type;

endpackage

`default_nettype wire

### hw/rtl/stbs_dp.sv
// Datapath of the sorted table binary search block: table memory, bounds, key and result.
// Depends on stbs_pkg for the command and status structs.
`default_nettype none

module stbs_dp #(
   parameter int TABLE_DEPTH = 1024
) (
   input  wire                         clock,
   input  wire                         reset,
   input  stbs_pkg::dp_cmd_type        cmd,
   output stbs_pkg::dp_status_type     status,
   input  wire  [9:0]                  entry_index,
   input  wire  [31:0]                 data_value,
   input  wire                         csr_valid,
   input  wire  [10:0]                 csr_data,
   input  wire                         rsp_tready,
   output logic                        rsp_valid,
   output logic                        rsp_found,
   output logic [9:0]                  rsp_position
);

   localparam int ADDR_W = $clog2(TABLE_DEPTH);
   localparam int CW     = $clog2(TABLE_DEPTH + 1);
   localparam int LW     = (CW > 11) ? CW : 11;

   logic [31:0]        mem [TABLE_DEPTH];

   logic [10:0]        len_ff;
   logic [CW-1:0]      low_ff, low_in;
   logic [CW-1:0]      hi_ff, hi_in;
   logic [ADDR_W-1:0]  mid_ff, mid_in;
   logic signed [31:0] key_ff;
   logic signed [31:0] rdata_ff;
   logic               rsp_valid_ff, rsp_valid_in;
   logic               rsp_found_ff;
   logic [9:0]         rsp_pos_ff;

   logic [LW-1:0]      wide_index;
   logic [LW-1:0]      wide_mid;
   logic [CW-1:0]      sat_len;
   logic [CW:0]        bound_sum;
   logic               key_lt, key_gt;

   assign wide_index = LW'(entry_index);
   assign wide_mid   = LW'(mid_ff);
   assign sat_len    = (LW'(len_ff) > LW'(TABLE_DEPTH)) ? CW'(TABLE_DEPTH) : CW'(len_ff);
   assign key_lt     = key_ff < rdata_ff;
   assign key_gt     = key_ff > rdata_ff;

   // Bounds are [low, hi): hi is one past the last candidate entry.
   always_comb begin
      low_in = low_ff;
      hi_in  = hi_ff;
      if (cmd.narrow) begin
         if (key_gt) begin
            low_in = CW'(mid_ff) + CW'(1);
         end
         if (key_lt) begin
            hi_in = CW'(mid_ff);
         end
      end
      bound_sum = {1'b0, low_in} + {1'b0, hi_in} - {{CW{1'b0}}, 1'b1};
      mid_in    = ADDR_W'(bound_sum >> 1);
   end

   assign status.hit        = !key_lt && !key_gt;
   assign status.next_empty = low_in >= hi_in;
   assign status.rsp_free   = !rsp_valid_ff || rsp_tready;

   always_ff @(posedge clock) begin
      if (cmd.wr && (wide_index < LW'(TABLE_DEPTH))) begin
         mem[wide_index[ADDR_W-1:0]] <= data_value;
      end
      if (cmd.probe) begin
         rdata_ff <= mem[mid_in];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.start) begin
         key_ff <= data_value;
         low_ff <= '0;
         hi_ff  <= sat_len;
      end else if (cmd.probe) begin
         low_ff <= low_in;
         hi_ff  <= hi_in;
         mid_ff <= mid_in;
      end
      if (cmd.finish) begin
         rsp_found_ff <= cmd.hit;
         rsp_pos_ff   <= cmd.hit ? wide_mid[9:0] : 10'd0;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.finish) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         len_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_valid) begin
            len_ff <= csr_data;
         end
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_found    = rsp_found_ff;
   assign rsp_position = rsp_pos_ff;

   a_probe_bounds_open : assert property (@(posedge clock) disable iff (reset)
      cmd.probe |=> (low_ff < hi_ff))
      else $error("probe issued with empty bounds");

   a_mid_inside_bounds : assert property (@(posedge clock) disable iff (reset)
      cmd.probe |=> ((CW'(mid_ff) >= low_ff) && (CW'(mid_ff) < hi_ff)))
      else $error("midpoint outside bounds");

   a_hi_within_depth : assert property (@(posedge clock) disable iff (reset)
      (cmd.start || cmd.probe) |=> (LW'(hi_ff) <= LW'(TABLE_DEPTH)))
      else $error("upper bound beyond table depth");

   a_miss_position_zero : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_found_ff) |-> (rsp_pos_ff == 10'd0))
      else $error("miss result with nonzero position");

endmodule

`default_nettype wire

### hw/rtl/stbs_ctrl.sv
// Controller of the sorted table binary search block: accepts beats and sequences the probes.
// Depends on stbs_pkg for command codes and the command and status structs.
`default_nettype none

module stbs_ctrl (
   input  wire                         clock,
   input  wire                         reset,
   input  wire                         req_tvalid,
   input  wire                         req_cmd,
   output logic                        req_tready,
   input  stbs_pkg::dp_status_type     status,
   output stbs_pkg::dp_cmd_type        cmd
);

   localparam logic [1:0] ST_IDLE  = 2'd0;
   localparam logic [1:0] ST_LOAD  = 2'd1;
   localparam logic [1:0] ST_PROBE = 2'd2;

   logic [1:0] state_ff, state_in;
   logic       accept;

   assign req_tready = (state_ff == ST_IDLE);
   assign accept     = req_tvalid && req_tready;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (req_cmd == stbs_pkg::CMD_SEARCH) begin
                  cmd.start = 1'b1;
                  state_in  = ST_LOAD;
               end else begin
                  cmd.wr = 1'b1;
               end
            end
         end
         ST_LOAD: begin
            // The result register must be free before a result is loaded; otherwise wait here.
            if (status.next_empty) begin
               if (status.rsp_free) begin
                  cmd.finish = 1'b1;
                  state_in   = ST_IDLE;
               end
            end else begin
               cmd.probe = 1'b1;
               state_in  = ST_PROBE;
            end
         end
         ST_PROBE: begin
            cmd.narrow = 1'b1;
            if (status.hit || status.next_empty) begin
               if (status.rsp_free) begin
                  cmd.finish = 1'b1;
                  cmd.hit    = status.hit;
                  state_in   = ST_IDLE;
               end
            end else begin
               cmd.probe = 1'b1;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   a_finish_not_probe : assert property (@(posedge clock) disable iff (reset)
      !(cmd.finish && cmd.probe))
      else $error("finish and probe in the same cycle");

   a_start_only_idle : assert property (@(posedge clock) disable iff (reset)
      (cmd.start || cmd.wr) |-> (state_ff == ST_IDLE && req_tvalid))
      else $error("beat taken outside idle");

   a_idle_after_finish : assert property (@(posedge clock) disable iff (reset)
      ((state_ff == ST_IDLE) && ($past(state_ff) != ST_IDLE) && !$past(reset))
         |-> $past(cmd.finish))
      else $error("search ended without a result");

endmodule

`default_nettype wire

### hw/rtl/sorted_table_binary_search.sv
// Top level of the sorted table binary search block.
// Instantiates stbs_ctrl and stbs_dp; depends on stbs_pkg.
`default_nettype none

// The block keeps a table of TABLE_DEPTH signed 32-bit entries in a single-port
// memory and answers binary search queries over its first table_length entries,
// which the user keeps sorted ascending. A request beat with req_tuser low writes
// one entry; writes may stream at one beat per cycle while no search is running,
// and give no response. A request beat with req_tuser high searches for the key
// in the data field and gives exactly one response beat: rsp_tuser is the found
// flag and rsp_tdata holds the position, zero on a miss. A search makes P probes,
// at most floor(log2(length)) + 1, before the block is ready again. The memory's
// one read port paces it: one entry is read and compared per cycle once the
// request is taken and the first read started, and the result then waits until
// the result register is free. Searches run one at a time; a finished response
// sits in an output register so the next request can be taken while it waits.
// The user writes table_length through the csr port only while the block is
// idle; the block does not enforce this. A value above TABLE_DEPTH acts as
// TABLE_DEPTH. Entries that are searched must have been written first.
module sorted_table_binary_search #(
   parameter int TABLE_DEPTH = 1024
) (
   input  wire          clock,
   input  wire          reset,
   // Request channel.
   input  wire          req_tvalid,
   output logic         req_tready,
   input  wire  [47:0]  req_tdata,   // [9:0] entry_index, [41:10] data_value, [47:42] zero.
   input  wire          req_tuser,   // [0] cmd: 0 write, 1 search.
   // Response channel.
   output logic         rsp_tvalid,
   input  wire          rsp_tready,
   output logic [15:0]  rsp_tdata,   // [9:0] position, [15:10] zero.
   output logic         rsp_tuser,   // [0] found.
   // Configuration write channel for table_length.
   input  wire          csr_valid,
   output logic         csr_ready,
   input  wire  [10:0]  csr_data
);

   stbs_pkg::dp_cmd_type    dp_cmd;
   stbs_pkg::dp_status_type dp_status;
   logic [9:0]              rsp_position;

   // The length register is always ready to take a beat.
   assign csr_ready = 1'b1;

   stbs_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_cmd    (req_tuser),
      .req_tready (req_tready),
      .status     (dp_status),
      .cmd        (dp_cmd)
   );

   stbs_dp #(
      .TABLE_DEPTH (TABLE_DEPTH)
   ) u_dp (
      .clock        (clock),
      .reset        (reset),
      .cmd          (dp_cmd),
      .status       (dp_status),
      .entry_index  (req_tdata[9:0]),
      .data_value   (req_tdata[41:10]),
      .csr_valid    (csr_valid),
      .csr_data     (csr_data),
      .rsp_tready   (rsp_tready),
      .rsp_valid    (rsp_tvalid),
      .rsp_found    (rsp_tuser),
      .rsp_position (rsp_position)
   );

   // The response payload is padded to whole bytes.
   assign rsp_tdata = {6'd0, rsp_position};

endmodule

`default_nettype wire

### dv/tb.sv
// Self-checking testbench for sorted_table_binary_search: a directed table of beats,
// then sorted tables with random searches and writes, checked against a local predictor.
// Depends on stbs_pkg and the sorted_table_binary_search RTL.
`timescale 1ns / 1ps

module tb;

   localparam int DEPTH          = 1024;
   localparam int LATENCY_CYCLES = 16;   // one search at a full table, with margin
   localparam int SHOWN_ERRORS   = 10;
   localparam logic [31:0] KEY_MIN = 32'h8000_0000;
   localparam logic [31:0] KEY_MAX = 32'h7FFF_FFFF;
   localparam longint MIN_VAL = -64'sd2147483648;
   localparam longint MAX_VAL = 64'sd2147483647;

   typedef struct packed {
      logic       found;
      logic [9:0] position;
   } answer_type;

   // One row of the directed plan. A length row writes table_length from value.
   typedef struct packed {
      logic        is_length;
      logic        cmd;
      logic [9:0]  index;
      logic [31:0] value;
      logic        typed;     // answer below is written out by hand
      answer_type  answer;
   } plan_row_type;

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [47:0] req_tdata  = '0;
   logic        req_tuser  = 1'b0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [15:0] rsp_tdata;
   logic        rsp_tuser;
   logic        csr_valid  = 1'b0;
   logic        csr_ready;
   logic [10:0] csr_data   = '0;

   // Predictor state: a copy of the table and of the length register.
   logic signed [31:0] mirror_entries [0:DEPTH-1];
   int unsigned        cur_length = 0;
   answer_type         pending_answers [$];
   plan_row_type       plan_rows [$];

   int error_count   = 0;
   int send_idle_pct = 0;
   int rsp_idle_pct  = 0;

   sorted_table_binary_search #(
      .TABLE_DEPTH(DEPTH)
   ) i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data)
   );

   always #1 clock = ~clock;

   // Response side backpressure.
   always @(posedge clock) begin
      rsp_tready <= ($urandom_range(99) >= rsp_idle_pct);
   end

   task automatic flag_error(string msg);
      error_count++;
      if (error_count <= SHOWN_ERRORS) begin
         $display("[%0t] ERROR: %s", $realtime, msg);
      end
   endtask

   // Lengths above the table depth act as the full table.
   function automatic int active_entries();
      return (cur_length > DEPTH) ? DEPTH : int'(cur_length);
   endfunction

   // Binary search over the mirrored table; the first equal probe wins.
   function automatic answer_type lookup_key(logic signed [31:0] key);
      int         lo, hi, mid;
      bit         done;
      answer_type ans;
      ans  = '0;
      done = 1'b0;
      lo   = 0;
      hi   = active_entries() - 1;
      while (!done && lo <= hi) begin
         mid = (lo + hi) / 2;
         if (key < mirror_entries[mid]) begin
            hi = mid - 1;
         end else if (key > mirror_entries[mid]) begin
            lo = mid + 1;
         end else begin
            ans.found    = 1'b1;
            ans.position = mid[9:0];
            done         = 1'b1;
         end
      end
      return ans;
   endfunction

   // Check every response beat against the oldest outstanding answer.
   always @(posedge clock) begin
      answer_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_answers.size() == 0) begin
            flag_error($sformatf("response with none pending: found=%0d tdata=0x%h",
                                 rsp_tuser, rsp_tdata));
         end else begin
            want = pending_answers.pop_front();
            if (rsp_tuser !== want.found || rsp_tdata !== {6'b0, want.position}) begin
               flag_error($sformatf("expected found=%0d position=%0d, got found=%0d tdata=0x%h",
                                    want.found, want.position, rsp_tuser, rsp_tdata));
            end
         end
      end
   end

   // Drives one request beat and holds it until accepted. Valid stays high on
   // return so that a following beat can go out back to back.
   task automatic send_beat(logic cmd, logic [9:0] idx, logic [31:0] value,
                            bit typed, answer_type typed_ans);
      answer_type ans;
      if ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < send_idle_pct);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= cmd;
      req_tdata  <= {6'b0, value, idx};
      do @(posedge clock); while (!req_tready);
      if (cmd == stbs_pkg::CMD_WRITE) begin
         mirror_entries[idx] = value;
      end else begin
         ans = typed ? typed_ans : lookup_key(value);
         pending_answers.push_back(ans);
      end
   endtask

   task automatic send_search(logic [31:0] key);
      send_beat(stbs_pkg::CMD_SEARCH, 10'($urandom_range(DEPTH - 1)), key, 1'b0, '0);
   endtask

   task automatic send_write(int idx, logic [31:0] value);
      send_beat(stbs_pkg::CMD_WRITE, idx[9:0], value, 1'b0, '0);
   endtask

   // Stop sending and wait for every outstanding response, then let the
   // block settle. Always waits on the clock before it returns.
   task automatic quiesce(int settle);
      req_tvalid <= 1'b0;
      do @(posedge clock); while (pending_answers.size() != 0);
      repeat (settle) @(posedge clock);
   endtask

   task automatic set_length(logic [10:0] len);
      quiesce(LATENCY_CYCLES);
      csr_valid <= 1'b1;
      csr_data  <= len;
      do @(posedge clock); while (!csr_ready);
      csr_valid  <= 1'b0;
      cur_length = len;
   endtask

   // Writes the whole table in ascending order; a small step gives many
   // duplicate runs, a large one spreads the values and clamps at the top.
   task automatic fill_entries(longint start, int max_step);
      longint v;
      v = start;
      for (int i = 0; i < DEPTH; i++) begin
         send_write(i, 32'(v));
         v = v + longint'($urandom_range(max_step));
         if (v > MAX_VAL) v = MAX_VAL;
      end
   endtask

   function automatic logic [10:0] pick_length(int k);
      case (k % 9)
         0:       return 11'd0;
         1:       return 11'd1;
         2:       return 11'd2047;
         3:       return 11'd1024;
         4:       return 11'd1025;
         5:       return 11'($urandom_range(16, 2));
         6:       return 11'($urandom_range(1023, 17));
         7:       return 11'($urandom_range(8, 3));
         default: return 11'($urandom_range(DEPTH, 1));
      endcase
   endfunction

   // Mostly searches for keys that are in the table or just beside them, with
   // writes that keep the order and a few that break it.
   task automatic random_item();
      int          eff, pick, i;
      longint      lo, hi;
      logic [31:0] v;
      eff  = active_entries();
      pick = $urandom_range(99);
      i    = (eff > 0) ? $urandom_range(eff - 1) : 0;
      // Now and then hold off until the block has answered everything.
      if ($urandom_range(49) == 0) quiesce(0);
      if (pick < 55 && eff > 0) begin
         send_search(mirror_entries[i]);
      end else if (pick < 63 && eff > 0) begin
         send_search(mirror_entries[i] + 32'd1);
      end else if (pick < 70 && eff > 0) begin
         send_search(mirror_entries[i] - 32'd1);
      end else if (pick < 78) begin
         case ($urandom_range(2))
            0:       send_search(KEY_MIN);
            1:       send_search(KEY_MAX);
            default: send_search($urandom);
         endcase
      end else if (pick < 93) begin
         if (eff == 0 || $urandom_range(3) == 0) i = $urandom_range(DEPTH - 1);
         lo = (i > 0) ? longint'(mirror_entries[i-1]) : MIN_VAL;
         hi = (i < DEPTH - 1) ? longint'(mirror_entries[i+1]) : MAX_VAL;
         if (lo > hi) v = mirror_entries[i];
         else v = 32'(lo + longint'($urandom) % (hi - lo + 1));
         send_write(i, v);
      end else begin
         send_write($urandom_range(DEPTH - 1), $urandom);
      end
   endtask

   function automatic plan_row_type mk_row(bit is_length, logic cmd, int idx,
                                           logic [31:0] value, bit typed, bit found,
                                           int pos);
      plan_row_type r;
      r.is_length       = is_length;
      r.cmd             = cmd;
      r.index           = idx[9:0];
      r.value           = value;
      r.typed           = typed;
      r.answer.found    = found;
      r.answer.position = pos[9:0];
      return r;
   endfunction

   initial begin
      // Directed plan. Only entries 0 to 3 and 1023 are written here, so every
      // length stays at 4 or below until the table is filled.
      //                      len cmd                   idx   value    typed fnd pos
      plan_rows.push_back(mk_row(0, stbs_pkg::CMD_SEARCH, 0,    32'd0,   1, 0, 0)); // empty table
      plan_rows.push_back(mk_row(0, stbs_pkg::CMD_SEARCH, 1023, KEY_MAX, 1, 0, 0));
      plan_rows.push_back(mk_row(0, stbs_pkg::CMD_WRITE,  0,    KEY_MIN, 0, 0, 0));
      plan_rows.push_back(mk_row(0, stbs_pkg::CMD_WRITE,  1,    -32'sd5, 0, 0, 0));
      plan_rows.push_back(mk_row(0, stbs_pkg::CMD_WRITE,  2,    32'd0,   0, 0, 0));
      plan_rows.push_back(mk_row(0, stbs_pkg::CMD_WRITE,  3,    32'd7,   0, 0, 0));
      plan_rows.push_back(mk_row(0, stbs_pkg::CMD_WRITE,  1023, KEY_MAX, 0, 0, 0));
      plan_rows.push_back(mk_row(1, stbs_pkg::CMD_WRITE,  0,    32'd1,   0, 0, 0));
      plan_rows.push_back(mk_row(0, stbs_pkg::CMD_SEARCH, 0,    KEY_MIN, 1, 1, 0));
      plan_rows.push_back(mk_row(0, stbs_pkg::CMD_SEARCH, 0,    KEY_MAX, 1, 0, 0));
      plan_rows.push_back(mk_row(1, stbs_pkg::CMD_WRITE,  0,    32'd4,   0, 0, 0));
      plan_rows.push_back(mk_row(0, stbs_pkg::CMD_SEARCH, 0,    -32'sd5, 0, 0, 0));
      plan_rows.push_back(mk_row(0, stbs_pkg::CMD_SEARCH, 0,    32'd7,   0, 0, 0));
      plan_rows.push_back(mk_row(0, stbs_pkg::CMD_SEARCH, 0,    32'd3,   0, 0, 0));
      plan_rows.push_back(mk_row(0, stbs_pkg::CMD_SEARCH, 0,    KEY_MIN, 0, 0, 0));
      plan_rows.push_back(mk_row(0, stbs_pkg::CMD_SEARCH, 0,    KEY_MAX, 0, 0, 0));
      plan_rows.push_back(mk_row(0, stbs_pkg::CMD_WRITE,  2,    -32'sd5, 0, 0, 0)); // duplicate
      plan_rows.push_back(mk_row(0, stbs_pkg::CMD_SEARCH, 0,    -32'sd5, 0, 0, 0));
      plan_rows.push_back(mk_row(0, stbs_pkg::CMD_WRITE,  3,    KEY_MIN, 0, 0, 0)); // unsorted
      plan_rows.push_back(mk_row(0, stbs_pkg::CMD_SEARCH, 0,    32'd7,   0, 0, 0));
      plan_rows.push_back(mk_row(0, stbs_pkg::CMD_SEARCH, 0,    KEY_MIN, 0, 0, 0));
      plan_rows.push_back(mk_row(1, stbs_pkg::CMD_WRITE,  0,    32'd3,   0, 0, 0));
      plan_rows.push_back(mk_row(0, stbs_pkg::CMD_SEARCH, 0,    -32'sd5, 0, 0, 0));

      repeat (5) @(posedge clock);
      reset <= 1'b0;

      send_idle_pct = 17;
      rsp_idle_pct  = 75;
      foreach (plan_rows[n]) begin
         if (plan_rows[n].is_length) begin
            set_length(plan_rows[n].value[10:0]);
         end else begin
            send_beat(plan_rows[n].cmd, plan_rows[n].index, plan_rows[n].value,
                      plan_rows[n].typed, plan_rows[n].answer);
         end
      end

      // Random part: three idling modes, each a run of phases with its own length.
      for (int blk = 0; blk < 3; blk++) begin
         case (blk)
            0: begin
               send_idle_pct = 17;
               rsp_idle_pct  = 75;
               fill_entries(MIN_VAL, 8_000_000);
            end
            1: begin
               send_idle_pct = 75;
               rsp_idle_pct  = 17;
            end
            default: begin
               send_idle_pct = 0;
               rsp_idle_pct  = 0;
               fill_entries(-longint'($urandom_range(2000)), 2);
            end
         endcase
         for (int ph = 0; ph < 7; ph++) begin
            set_length(pick_length(blk * 7 + ph));
            repeat (34) random_item();
         end
      end

      quiesce(LATENCY_CYCLES);
      if (error_count == 0) begin
         $display("sorted_table_binary_search verification clean");
      end else begin
         $display("sorted_table_binary_search verification failed");
      end
      $finish;
   end

   // Watchdog, far beyond the slowest legal run.
   initial begin
      #2_000_000;
      $display("sorted_table_binary_search verification failed");
      $finish;
   end

endmodule
